### rtl/pwmd_pkg.sv
// Shared constants, codes and types of the PWM ratio-to-level decoder.
package pwmd_pkg;

    // Default sizing
    localparam int PWMD_CHANNELS   = 4;
    localparam int PWMD_COUNT_BITS = 16;

    // Fixed field widths
    localparam int PWMD_PIN_BITS   = 4;
    localparam int PWMD_OUT_BITS   = 8;
    localparam int PWMD_LIMIT_BITS = 16;
    localparam int PWMD_IDX_BITS   = 8;
    localparam int PWMD_CFG_BITS   = 16;

    // Configuration register indexes
    localparam logic [PWMD_IDX_BITS-1:0] REG_QUAD_MODE     = 8'd0;
    localparam logic [PWMD_IDX_BITS-1:0] REG_INPUT_INVERT  = 8'd1;
    localparam logic [PWMD_IDX_BITS-1:0] REG_OUTPUT_INVERT = 8'd2;
    localparam logic [PWMD_IDX_BITS-1:0] REG_COUNT_LIMIT   = 8'd3;

    localparam logic [PWMD_LIMIT_BITS-1:0] PWMD_LIMIT_RESET = 16'hFFFF;

    // Channel phase codes
    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    // Ratio scale and level thresholds (ratio <= threshold picks the lower level)
    localparam int PWMD_SCALE   = 100;
    localparam int PWMD_QUAD_T1 = 25;
    localparam int PWMD_QUAD_T2 = 50;
    localparam int PWMD_QUAD_T3 = 75;
    localparam int PWMD_TRI_T1  = 33;
    localparam int PWMD_TRI_T2  = 66;

    // Per-channel outcome of one update
    typedef struct packed {
        logic eval;   // low-to-high edge after a low phase: new level
        logic clear;  // count limit reached: channel dropped
    } t_calc_flags;

endpackage

### rtl/pwmd_state_mem.sv
// Per-channel state memory: one write port, one read port, registered read.
module pwmd_state_mem
    import pwmd_pkg::*;
#(
    parameter int DEPTH = PWMD_CHANNELS,
    parameter int WIDTH = 2 + 2 * PWMD_COUNT_BITS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_valid;

    // Storage array, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Entry valid bits: an unwritten entry reads as the all-zero reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

### rtl/pwmd_chan_calc.sv
// Channel update stage: next phase and counts, ratio products, level select.
module pwmd_chan_calc
    import pwmd_pkg::*;
#(
    parameter int COUNT_BITS = PWMD_COUNT_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [2*COUNT_BITS+1:0]    i_rd_data,
    input  logic                       i_sample,
    input  logic                       i_quad,
    input  logic [PWMD_LIMIT_BITS-1:0] i_limit,
    input  logic [1:0]                 i_level_old,
    output logic [2*COUNT_BITS+1:0]    o_wr_data,
    output logic [1:0]                 o_level,
    output t_calc_flags                o_flags
);

    localparam int CB = COUNT_BITS;
    localparam int LW = (CB > PWMD_LIMIT_BITS) ? CB : PWMD_LIMIT_BITS;
    localparam int PW = CB + 7;
    localparam logic [CB-1:0] CNT_MAX = '1;

    function automatic logic [CB-1:0] bump(input logic [CB-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    logic [1:0]    ph;
    logic [CB-1:0] hi;
    logic [CB-1:0] lo;
    logic [CB-1:0] lo_eff;
    logic [1:0]    n_ph;
    logic [CB-1:0] n_hi;
    logic [CB-1:0] n_lo;
    logic          n_eval;
    logic          n_clear;
    logic          counted;
    logic [PW-1:0] n_p_hi;
    logic [PW-1:0] n_p1;
    logic [PW-1:0] n_p2;
    logic [PW-1:0] n_p3;

    logic [2*CB+1:0] r_wr_data;
    logic            r_eval;
    logic            r_clear;
    logic [PW-1:0]   r_p_hi;
    logic [PW-1:0]   r_p1;
    logic [PW-1:0]   r_p2;
    logic [PW-1:0]   r_p3;

    logic       lt1;
    logic       lt2;
    logic       lt3;
    logic [1:0] quant;

    assign {ph, hi, lo} = i_rd_data;
    assign lo_eff = (lo == '0) ? CB'(1) : lo;

    // Phase tracking, counting and limit check
    always_comb begin
        n_ph    = ph;
        n_hi    = hi;
        n_lo    = lo;
        n_eval  = 1'b0;
        n_clear = 1'b0;
        counted = 1'b0;
        if (i_sample) begin
            counted = 1'b1;
            n_eval  = (ph == PH_LOW);
            n_ph    = PH_HIGH;
            n_lo    = n_eval ? '0 : lo;
            n_hi    = bump(n_eval ? '0 : hi);
        end else if (ph != PH_NONE) begin
            counted = 1'b1;
            n_ph    = PH_LOW;
            n_lo    = bump(lo);
        end
        if (counted && (LW'(n_hi) >= LW'(i_limit) || LW'(n_lo) >= LW'(i_limit))) begin
            n_clear = 1'b1;
            n_ph    = PH_NONE;
            n_hi    = '0;
            n_lo    = '0;
        end
    end

    // ratio <= T  <=>  hi*100 < (T+1)*lo, so no divider is needed
    assign n_p_hi = PW'(hi) * PW'(PWMD_SCALE);
    assign n_p1   = PW'(lo_eff) * (i_quad ? PW'(PWMD_QUAD_T1 + 1) : PW'(PWMD_TRI_T1 + 1));
    assign n_p2   = PW'(lo_eff) * (i_quad ? PW'(PWMD_QUAD_T2 + 1) : PW'(PWMD_TRI_T2 + 1));
    assign n_p3   = PW'(lo_eff) * PW'(PWMD_QUAD_T3 + 1);

    // Stage register, payload only
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wr_data <= {n_ph, n_hi, n_lo};
            r_eval    <= n_eval;
            r_clear   <= n_clear;
            r_p_hi    <= n_p_hi;
            r_p1      <= n_p1;
            r_p2      <= n_p2;
            r_p3      <= n_p3;
        end
    end

    // Threshold compare and level pick
    assign lt1 = r_p_hi < r_p1;
    assign lt2 = r_p_hi < r_p2;
    assign lt3 = r_p_hi < r_p3;

    always_comb begin
        if (lt1) begin
            quant = 2'd0;
        end else if (lt2) begin
            quant = 2'd1;
        end else if (i_quad && lt3) begin
            quant = 2'd2;
        end else begin
            quant = i_quad ? 2'd3 : 2'd2;
        end
    end

    assign o_wr_data     = r_wr_data;
    assign o_level       = r_clear ? 2'd0 : (r_eval ? quant : i_level_old);
    assign o_flags.eval  = r_eval;
    assign o_flags.clear = r_clear;

endmodule

### rtl/pwm_ratio_to_level_decoder.sv
// Top level of the PWM ratio-to-level decoder: sequencer, registers, output stage.
//
// Use: each input beat on (i_in_valid, o_in_ready, i_pin_levels) is one sample
// tick of the input pins. For every tick the block returns exactly one output
// beat on (o_out_valid, i_out_ready, o_out_pins, o_updated): the decoded levels
// of all channels after that tick, and which channels got a new level or dropped.
// Channel state (phase, high and low counts) lives in a one-port-per-direction
// memory; channels are visited one after the other with a read, an update and a
// write-back state each; the result is then loaded into the output register and
// the block returns to idle, where alone it takes a new tick. Level thresholds
// are checked against scaled low counts, so no divider sits in the path.
// The config channel (index, data) is always ready and should only be written
// while no tick is in flight and no result is waiting.
// Reset (synchronous, active low) drops all channels to no signal, level zero,
// and loads register defaults (count limit 65535).
// When the receiver stalls, the finished result stays in the output register;
// one more tick is accepted and processed, then held until the output drains.
module pwm_ratio_to_level_decoder
    import pwmd_pkg::*;
#(
    parameter int CHANNELS   = PWMD_CHANNELS,
    parameter int COUNT_BITS = PWMD_COUNT_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [PWMD_PIN_BITS-1:0]   i_pin_levels,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [PWMD_OUT_BITS-1:0]   o_out_pins,
    output logic [PWMD_PIN_BITS-1:0]   o_updated,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [PWMD_IDX_BITS-1:0]   i_cfg_index,
    input  logic [PWMD_CFG_BITS-1:0]   i_cfg_data
);

    localparam int AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW  = 2 + 2 * COUNT_BITS;
    localparam int VIS = (CHANNELS < PWMD_PIN_BITS) ? CHANNELS : PWMD_PIN_BITS;
    localparam logic [AW-1:0] LAST_CH = AW'(CHANNELS - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                 r_state;
    logic [AW-1:0]              r_ch;
    logic [CHANNELS-1:0]        r_samples;
    logic [CHANNELS-1:0]        r_upd;
    logic [1:0]                 r_level [CHANNELS];
    logic                       r_quad;
    logic [PWMD_PIN_BITS-1:0]   r_in_inv;
    logic [PWMD_OUT_BITS-1:0]   r_out_inv;
    logic [PWMD_LIMIT_BITS-1:0] r_limit;
    logic                       r_out_valid;
    logic [PWMD_OUT_BITS-1:0]   r_out_pins;
    logic [PWMD_PIN_BITS-1:0]   r_out_upd;

    logic [CHANNELS-1:0]        n_samples;
    logic [PWMD_OUT_BITS-1:0]   n_drive;
    logic [PWMD_PIN_BITS-1:0]   n_upd_vis;
    logic                       in_fire;
    logic                       out_load;
    logic                       mem_rd_en;
    logic                       mem_wr_en;
    logic [SW-1:0]              mem_rd_data;
    logic [SW-1:0]              calc_wr_data;
    logic [1:0]                 calc_level;
    t_calc_flags                calc_flags;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign mem_rd_en   = (r_state == S_READ);
    assign mem_wr_en   = (r_state == S_WRITE);
    assign o_cfg_ready = 1'b1;

    // Sampled pins after inversion; channels past the pin field see low
    always_comb begin
        n_samples = '0;
        for (int k = 0; k < VIS; k++) begin
            n_samples[k] = i_pin_levels[k] ^ r_in_inv[k];
        end
    end

    // Output pins and update bits of the visible channels
    always_comb begin
        n_drive   = '0;
        n_upd_vis = '0;
        for (int k = 0; k < VIS; k++) begin
            n_drive[2*k +: 2] = r_level[k];
            n_upd_vis[k]      = r_upd[k];
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quad    <= 1'b0;
            r_in_inv  <= '0;
            r_out_inv <= '0;
            r_limit   <= PWMD_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_QUAD_MODE:     r_quad    <= i_cfg_data[0];
                REG_INPUT_INVERT:  r_in_inv  <= i_cfg_data[PWMD_PIN_BITS-1:0];
                REG_OUTPUT_INVERT: r_out_inv <= i_cfg_data[PWMD_OUT_BITS-1:0];
                REG_COUNT_LIMIT:   r_limit   <= i_cfg_data[PWMD_LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Channel sequencer: read, update, write back per channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= '0;
            r_upd   <= '0;
            for (int k = 0; k < CHANNELS; k++) begin
                r_level[k] <= 2'd0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_samples <= n_samples;
                        r_upd     <= '0;
                        r_ch      <= '0;
                        r_state   <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_level[r_ch] <= calc_level;
                    r_upd[r_ch]   <= calc_flags.eval || calc_flags.clear;
                    if (r_ch == LAST_CH) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pins <= n_drive ^ r_out_inv;
            r_out_upd  <= n_upd_vis;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_pins  = r_out_pins;
    assign o_updated   = r_out_upd;

    pwmd_state_mem #(
        .DEPTH (CHANNELS),
        .WIDTH (SW),
        .AW    (AW)
    ) u_state_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_ch),
        .i_wr_data (calc_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_ch),
        .o_rd_data (mem_rd_data)
    );

    pwmd_chan_calc #(
        .COUNT_BITS (COUNT_BITS)
    ) u_chan_calc (
        .i_clk       (i_clk),
        .i_en        (r_state == S_CALC),
        .i_rd_data   (mem_rd_data),
        .i_sample    (r_samples[r_ch]),
        .i_quad      (r_quad),
        .i_limit     (r_limit),
        .i_level_old (r_level[r_ch]),
        .o_wr_data   (calc_wr_data),
        .o_level     (calc_level),
        .o_flags     (calc_flags)
    );

`ifndef SYNTHESIS
    // Channel pointer stays inside the state memory
    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ch <= LAST_CH)
        else $error("channel pointer out of range");

    // A result is only loaded after the last channel was written back
    a_load_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> $past(r_state) == S_WRITE && $past(r_ch) == LAST_CH
                     || $past(r_state) == S_DONE)
        else $error("result loaded before all channels were updated");

    // Write-back of a channel follows its read, with the update state between
    a_rmw_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_rd_en |=> ##1 mem_wr_en && r_ch == $past(r_ch, 2))
        else $error("state write-back out of order");

    // No new tick while a channel update is under way
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("tick accepted while busy");
`endif

endmodule

### verif/tb_pwm_ratio_to_level_decoder.sv
// Self-checking testbench of the PWM ratio-to-level decoder: tick driver, level monitor, predictor.
`timescale 1ns / 100ps

module tb_pwm_ratio_to_level_decoder;
    import pwmd_pkg::*;

    localparam int RAND_PHASES     = 12;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int SETTLE_CYCLES   = 16;      // longer than one tick period of the decoder
    localparam int CYCLE_LIMIT     = 500000;

    // One expected output beat
    typedef struct {
        logic [PWMD_OUT_BITS-1:0] pins;
        logic [PWMD_PIN_BITS-1:0] upd;
        int unsigned              tick;
    } t_level_word;

    logic                     i_clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     tick_valid = 1'b0;
    logic [PWMD_PIN_BITS-1:0] tick_pins = '0;
    logic                     level_ready = 1'b0;
    logic                     reg_wr_valid = 1'b0;
    logic [PWMD_IDX_BITS-1:0] reg_wr_index = '0;
    logic [PWMD_CFG_BITS-1:0] reg_wr_data = '0;

    logic                     o_in_ready;
    logic                     o_out_valid;
    logic [PWMD_OUT_BITS-1:0] o_out_pins;
    logic [PWMD_PIN_BITS-1:0] o_updated;
    logic                     o_cfg_ready;

    // Predictor copy of channel state and registers
    logic [1:0]                 ch_phase [PWMD_CHANNELS];
    logic [PWMD_COUNT_BITS-1:0] ch_high  [PWMD_CHANNELS];
    logic [PWMD_COUNT_BITS-1:0] ch_low   [PWMD_CHANNELS];
    logic [1:0]                 ch_level [PWMD_CHANNELS];
    logic                       cfg_quad;
    logic [PWMD_PIN_BITS-1:0]   cfg_in_inv;
    logic [PWMD_OUT_BITS-1:0]   cfg_out_inv;
    logic [PWMD_LIMIT_BITS-1:0] cfg_limit;

    logic [PWMD_PIN_BITS-1:0] tick_queue [$];
    t_level_word              level_queue [$];

    int          seg_hi [PWMD_CHANNELS];
    int          seg_lo [PWMD_CHANNELS];
    int          seg_off [PWMD_CHANNELS];
    int          idle_pct = 0;
    int          send_gap = 0;
    int          recv_stall = 0;
    int          fail_cnt = 0;
    int unsigned ticks_sent = 0;
    int unsigned results_checked = 0;
    int unsigned level_events = 0;
    int unsigned settings_cnt = 0;
    int unsigned cycle_cnt = 0;

    pwm_ratio_to_level_decoder u_top (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (tick_valid),
        .o_in_ready   (o_in_ready),
        .i_pin_levels (tick_pins),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (level_ready),
        .o_out_pins   (o_out_pins),
        .o_updated    (o_updated),
        .i_cfg_valid  (reg_wr_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (reg_wr_index),
        .i_cfg_data   (reg_wr_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Advance the channel state by one sample tick and form the output beat
    task automatic decode_tick(input logic [PWMD_PIN_BITS-1:0] pins,
                               output logic [PWMD_OUT_BITS-1:0] drive_o,
                               output logic [PWMD_PIN_BITS-1:0] upd_o);
        logic       s;
        logic [63:0] den;
        logic [63:0] ratio;
        logic [PWMD_OUT_BITS-1:0] drive;
        logic [PWMD_PIN_BITS-1:0] upd;
        drive = '0;
        upd   = '0;
        for (int k = 0; k < PWMD_CHANNELS; k++) begin
            s = pins[k] ^ cfg_in_inv[k];
            if (s) begin
                // rising edge after a low phase: quantize high/low ratio
                if (ch_phase[k] == PH_LOW) begin
                    den   = (ch_low[k] == '0) ? 64'd1 : 64'(ch_low[k]);
                    ratio = (64'(ch_high[k]) * PWMD_SCALE) / den;
                    if (cfg_quad)
                        ch_level[k] = (ratio <= PWMD_QUAD_T1) ? 2'd0 :
                                      (ratio <= PWMD_QUAD_T2) ? 2'd1 :
                                      (ratio <= PWMD_QUAD_T3) ? 2'd2 : 2'd3;
                    else
                        ch_level[k] = (ratio <= PWMD_TRI_T1) ? 2'd0 :
                                      (ratio <= PWMD_TRI_T2) ? 2'd1 : 2'd2;
                    ch_high[k] = '0;
                    ch_low[k]  = '0;
                    upd[k]     = 1'b1;
                end
                ch_phase[k] = PH_HIGH;
                if (ch_high[k] != '1)
                    ch_high[k] = ch_high[k] + 1'b1;
            end else if (ch_phase[k] != PH_NONE) begin
                ch_phase[k] = PH_LOW;
                if (ch_low[k] != '1)
                    ch_low[k] = ch_low[k] + 1'b1;
            end
            // a low sample while idle is not counted and never hits the limit
            if (ch_phase[k] != PH_NONE &&
                (ch_high[k] >= cfg_limit || ch_low[k] >= cfg_limit)) begin
                ch_phase[k] = PH_NONE;
                ch_high[k]  = '0;
                ch_low[k]   = '0;
                ch_level[k] = 2'd0;
                upd[k]      = 1'b1;
            end
            drive[2*k +: 2] = ch_level[k];
        end
        level_events += $countones(upd);
        drive_o = drive ^ cfg_out_inv;
        upd_o   = upd;
    endtask

    task automatic report_mismatch(input string what, input int unsigned tick,
                                   input logic [PWMD_OUT_BITS-1:0] want,
                                   input logic [PWMD_OUT_BITS-1:0] got);
        fail_cnt++;
        $display("MISMATCH tick %0d %s: expected %h got %h", tick, what, want, got);
    endtask

    // Register write beat; the predictor takes the value when the beat is accepted
    task automatic cfg_write(input logic [PWMD_IDX_BITS-1:0] idx,
                             input logic [PWMD_CFG_BITS-1:0] data);
        @(posedge i_clk);
        reg_wr_valid <= 1'b1;
        reg_wr_index <= idx;
        reg_wr_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        reg_wr_valid <= 1'b0;
        case (idx)
            REG_QUAD_MODE:     cfg_quad    = data[0];
            REG_INPUT_INVERT:  cfg_in_inv  = data[PWMD_PIN_BITS-1:0];
            REG_OUTPUT_INVERT: cfg_out_inv = data[PWMD_OUT_BITS-1:0];
            REG_COUNT_LIMIT:   cfg_limit   = data[PWMD_LIMIT_BITS-1:0];
            default: ;
        endcase
    endtask

    // Sender idle: nothing queued, nothing offered, every result back
    task automatic wait_drained();
        while (tick_queue.size() != 0 || tick_valid || level_queue.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Queue n ticks of a PWM pattern given by seg_hi/seg_lo/seg_off per channel
    task automatic queue_pwm(input int n);
        logic [PWMD_PIN_BITS-1:0] pins;
        for (int t = 0; t < n; t++) begin
            for (int k = 0; k < PWMD_CHANNELS; k++)
                pins[k] = ((t + seg_off[k]) % (seg_hi[k] + seg_lo[k])) < seg_hi[k];
            tick_queue.push_back(pins);
        end
    endtask

    // Tick driver: offers queued ticks, predicts each accepted one
    always @(posedge i_clk) begin : tick_drv
        logic                     accepted;
        t_level_word              want;
        accepted = tick_valid && o_in_ready;
        if (!rst_n) begin
            tick_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (accepted) begin
                decode_tick(tick_pins, want.pins, want.upd);
                want.tick = ticks_sent;
                level_queue.push_back(want);
                ticks_sent++;
            end
            if (!tick_valid || accepted) begin
                if (send_gap > 0) begin
                    send_gap   <= send_gap - 1;
                    tick_valid <= 1'b0;
                end else if (tick_queue.size() != 0 && idle_pct > 0 &&
                             $urandom_range(0, 99) < idle_pct) begin
                    send_gap   <= $urandom_range(0, 13);
                    tick_valid <= 1'b0;
                end else if (tick_queue.size() != 0) begin
                    tick_valid <= 1'b1;
                    tick_pins  <= tick_queue.pop_front();
                end else begin
                    tick_valid <= 1'b0;
                end
            end
        end
    end

    // Level monitor: random back-pressure, compares each beat with the oldest prediction
    always @(posedge i_clk) begin : level_mon
        t_level_word want;
        if (!rst_n) begin
            level_ready <= 1'b0;
            recv_stall  <= 0;
        end else begin
            if (o_out_valid && level_ready) begin
                if (level_queue.size() == 0) begin
                    report_mismatch("beat with no tick pending", ticks_sent, '0, o_out_pins);
                end else begin
                    want = level_queue.pop_front();
                    if (o_out_pins !== want.pins)
                        report_mismatch("out_pins", want.tick, want.pins, o_out_pins);
                    if (o_updated !== want.upd)
                        report_mismatch("updated", want.tick, 8'(want.upd), 8'(o_updated));
                    results_checked++;
                end
            end
            if (recv_stall > 0) begin
                recv_stall  <= recv_stall - 1;
                level_ready <= 1'b0;
            end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                recv_stall  <= $urandom_range(0, 13);
                level_ready <= 1'b0;
            end else begin
                level_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, level_queue.size());
            $display("pwm_ratio_to_level_decoder test failed");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        int count;
        int n;
        int pick;
        logic [PWMD_CFG_BITS-1:0] q_data;
        logic [PWMD_CFG_BITS-1:0] ii_data;
        logic [PWMD_CFG_BITS-1:0] oi_data;
        logic [PWMD_CFG_BITS-1:0] lim_data;

        for (int k = 0; k < PWMD_CHANNELS; k++) begin
            ch_phase[k] = PH_NONE;
            ch_high[k]  = '0;
            ch_low[k]   = '0;
            ch_level[k] = 2'd0;
        end
        cfg_quad    = 1'b0;
        cfg_in_inv  = '0;
        cfg_out_inv = '0;
        cfg_limit   = PWMD_LIMIT_RESET;

        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset registers, idle lows ignored, full-high ratio,
        // tri-level boundaries 33 and 66
        idle_pct = 20;
        settings_cnt++;
        tick_queue.push_back(4'h0);
        tick_queue.push_back(4'hF);
        tick_queue.push_back(4'h0);
        tick_queue.push_back(4'hF);
        seg_hi  = '{1, 2, 2, 3};
        seg_lo  = '{3, 3, 1, 4};
        seg_off = '{0, 0, 0, 0};
        queue_pwm(12);
        wait_drained();

        // Directed: quad mode, inversions, masked data
        cfg_write(REG_QUAD_MODE, 16'hFFFF);
        cfg_write(REG_INPUT_INVERT, 16'h7A55);
        cfg_write(REG_OUTPUT_INVERT, 16'h12FF);
        settings_cnt++;
        @(negedge i_clk);
        seg_hi = '{1, 1, 1, 3};
        seg_lo = '{3, 3, 1, 1};
        queue_pwm(10);
        wait_drained();

        // Directed: limit of one, writes to unmapped indexes are dropped
        cfg_write(REG_COUNT_LIMIT, 16'h0001);
        cfg_write(REG_INPUT_INVERT, 16'hFFF0);
        cfg_write(8'd4, 16'hFFFF);
        cfg_write(8'hFF, 16'h0000);
        settings_cnt++;
        @(negedge i_clk);
        tick_queue.push_back(4'hF);
        tick_queue.push_back(4'h0);
        tick_queue.push_back(4'hF);
        tick_queue.push_back(4'hF);
        tick_queue.push_back(4'h0);
        wait_drained();

        // Random phases: PWM segments with random duty, some noise
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 0) begin
                q_data = '0; ii_data = '0; oi_data = '0; lim_data = 16'hFFFF;
            end else if (p == 1) begin
                q_data = '1; ii_data = '1; oi_data = '1; lim_data = 16'hFFFF;
            end else begin
                q_data  = PWMD_CFG_BITS'($urandom);
                ii_data = PWMD_CFG_BITS'($urandom);
                oi_data = PWMD_CFG_BITS'($urandom);
                pick    = $urandom_range(0, 5);
                case (pick)
                    0:       lim_data = 16'd1;
                    1:       lim_data = 16'd2;
                    2:       lim_data = PWMD_CFG_BITS'($urandom_range(3, 12));
                    3:       lim_data = PWMD_CFG_BITS'($urandom_range(13, 80));
                    4:       lim_data = 16'hFFFF;
                    default: lim_data = PWMD_CFG_BITS'($urandom);
                endcase
            end
            cfg_write(REG_QUAD_MODE, q_data);
            cfg_write(REG_INPUT_INVERT, ii_data);
            cfg_write(REG_OUTPUT_INVERT, oi_data);
            cfg_write(REG_COUNT_LIMIT, lim_data);
            if ($urandom_range(0, 3) == 0)
                cfg_write(PWMD_IDX_BITS'($urandom_range(4, 255)), PWMD_CFG_BITS'($urandom));
            settings_cnt++;
            @(negedge i_clk);

            // no idling in the closing phases
            if (p >= RAND_PHASES - 2) begin
                idle_pct = 0;
            end else begin
                pick = $urandom_range(0, 2);
                idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 30;
            end

            count = 0;
            while (count < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 99) < 85) begin
                    pick = $urandom_range(0, 9);
                    for (int k = 0; k < PWMD_CHANNELS; k++) begin
                        seg_hi[k]  = (pick < 7) ? $urandom_range(1, 8) : $urandom_range(1, 40);
                        seg_lo[k]  = (pick < 7) ? $urandom_range(1, 8) : $urandom_range(1, 40);
                        seg_off[k] = $urandom_range(0, seg_hi[k] + seg_lo[k] - 1);
                    end
                    n = $urandom_range(10, 60);
                    queue_pwm(n);
                end else begin
                    n = $urandom_range(3, 15);
                    repeat (n) tick_queue.push_back(PWMD_PIN_BITS'($urandom_range(0, 15)));
                end
                count += n;
            end
            wait_drained();
        end

        $display("covered %0d sample ticks, %0d checked beats, %0d register settings",
                 ticks_sent, results_checked, settings_cnt);
        $display("tri and quad levels, limits 1 to 65535, both inversions, %0d level changes",
                 level_events);
        if (fail_cnt == 0) begin
            $display("pwm_ratio_to_level_decoder test passed");
        end else begin
            $display("%0d mismatches", fail_cnt);
            $display("pwm_ratio_to_level_decoder test failed");
        end
        $finish;
    end

endmodule

### pwm_ratio_to_level_decoder.f
rtl/pwmd_pkg.sv
rtl/pwmd_state_mem.sv
rtl/pwmd_chan_calc.sv
rtl/pwm_ratio_to_level_decoder.sv
verif/tb_pwm_ratio_to_level_decoder.sv
